FILE: sv/mfm_pkg.sv
`timescale 1ns / 1ps
package mfm_pkg;

  localparam int DIM_DEF = 10;
  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;

  localparam logic CMD_FLIP  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_PT,
    ST_PT_DATA,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_DONE
  } mfm_state_t;

endpackage

FILE: sv/mfm_bitmem.sv
`timescale 1ns / 1ps
module mfm_bitmem import mfm_pkg::*; #(
  parameter int AW = DIM_DEF
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic          wd,
  input  logic [AW-1:0] ra,
  output logic          rd
);

  localparam int DEPTH = 1 << AW;

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    rd <= mem[ra];
  end

endmodule

FILE: sv/monotone_function_flip_mincut.sv
`timescale 1ns / 1ps
// Tracks a Boolean function on a DIM-bit hypercube together with its minimal-cut
// flags, the count of true points and the count of flagged points. Each input
// word (cmd, index) gives one result word. After reset the block runs a clearing
// pass over both bit memories, with in_stall high. A query reads the point and
// its flag and moves them to the result register; a flip also writes the
// inverted point and re-evaluates each of its DIM neighbors by reading that
// neighbor's DIM neighbor bits one per cycle through the single read port of the
// truth-table memory, then updating the neighbor's flag in a last step. The next
// word is taken in the idle state. A new word is accepted while a finished
// result still waits in the output register; the next result then waits in the
// last step, with in_stall high, until the output register is free.
module monotone_function_flip_mincut import mfm_pkg::*; #(
  parameter int DIM = DIM_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic [INDEX_W-1:0] index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               point_value,
  output logic               point_is_cut,
  output logic [COUNT_W-1:0] true_count,
  output logic [COUNT_W-1:0] cut_count
);

  localparam int CW = DIM + 1;

  mfm_state_t state, state_next;

  logic [DIM-1:0] clr_addr, clr_addr_next;
  logic           cmd_r, cmd_r_next;
  logic [DIM-1:0] idx_r, idx_r_next;
  logic [DIM-1:0] kmask, kmask_next;
  logic [DIM-1:0] jmask, jmask_next;
  logic [DIM-1:0] jmask_d, jmask_d_next;
  logic           ok, ok_next;
  logic           pv, pv_next;
  logic           pc, pc_next;
  logic [CW-1:0]  true_total, true_total_next;
  logic [CW-1:0]  cut_total, cut_total_next;
  logic           out_valid_next;
  logic           point_value_next, point_is_cut_next;
  logic [COUNT_W-1:0] true_count_next, cut_count_next;

  logic           t_we, t_wd, t_rd;
  logic [DIM-1:0] t_wa, t_ra;
  logic           c_we, c_wd, c_rd;
  logic [DIM-1:0] c_wa, c_ra;

  logic [DIM-1:0] q;
  logic           scan_good;
  logic           ok_final;

  mfm_bitmem #(.AW(DIM)) u_truth (
    .clk (clk),
    .we  (t_we),
    .wa  (t_wa),
    .wd  (t_wd),
    .ra  (t_ra),
    .rd  (t_rd)
  );

  mfm_bitmem #(.AW(DIM)) u_cut (
    .clk (clk),
    .we  (c_we),
    .wa  (c_wa),
    .wd  (c_wd),
    .ra  (c_ra),
    .rd  (c_rd)
  );

  // neighbor under evaluation and the check of the bit that just came back
  assign q         = idx_r ^ kmask;
  assign scan_good = t_rd ^ (|(q & jmask_d));
  assign ok_final  = ok & scan_good;

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      true_total <= '0;
      cut_total  <= CW'(1);
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      true_total <= true_total_next;
      cut_total  <= cut_total_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_r_next;
    idx_r        <= idx_r_next;
    kmask        <= kmask_next;
    jmask        <= jmask_next;
    jmask_d      <= jmask_d_next;
    ok           <= ok_next;
    pv           <= pv_next;
    pc           <= pc_next;
    point_value  <= point_value_next;
    point_is_cut <= point_is_cut_next;
    true_count   <= true_count_next;
    cut_count    <= cut_count_next;
  end

  always_comb begin
    state_next        = state;
    clr_addr_next     = clr_addr;
    cmd_r_next        = cmd_r;
    idx_r_next        = idx_r;
    kmask_next        = kmask;
    jmask_next        = jmask;
    jmask_d_next      = jmask_d;
    ok_next           = ok;
    pv_next           = pv;
    pc_next           = pc;
    true_total_next   = true_total;
    cut_total_next    = cut_total;
    point_value_next  = point_value;
    point_is_cut_next = point_is_cut;
    true_count_next   = true_count;
    cut_count_next    = cut_count;
    out_valid_next    = out_valid & out_stall;

    t_we = 1'b0;
    t_wa = idx_r;
    t_wd = 1'b0;
    t_ra = idx_r;
    c_we = 1'b0;
    c_wa = q;
    c_wd = 1'b0;
    c_ra = q;

    unique case (state)
      ST_CLEAR: begin
        t_we = 1'b1;
        t_wa = clr_addr;
        t_wd = 1'b0;
        c_we = 1'b1;
        c_wa = clr_addr;
        c_wd = &clr_addr;
        clr_addr_next = clr_addr + DIM'(1);
        if (&clr_addr) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd_r_next = cmd;
          idx_r_next = DIM'(index);
          state_next = ST_RD_PT;
        end
      end
      ST_RD_PT: begin
        t_ra = idx_r;
        c_ra = idx_r;
        state_next = ST_PT_DATA;
      end
      ST_PT_DATA: begin
        pv_next = t_rd ^ (cmd_r == CMD_FLIP);
        pc_next = c_rd;
        if (cmd_r == CMD_QUERY) begin
          state_next = ST_DONE;
        end else begin
          t_we = 1'b1;
          t_wa = idx_r;
          t_wd = ~t_rd;
          true_total_next = t_rd ? (true_total - CW'(1)) : (true_total + CW'(1));
          kmask_next   = DIM'(1);
          jmask_next   = DIM'(1);
          jmask_d_next = '0;
          ok_next      = 1'b1;
          state_next   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // issue one neighbor read per cycle, fold in the one from last cycle
        t_ra = q ^ jmask;
        c_ra = q;
        ok_next      = ok & ((jmask_d == '0) | scan_good);
        jmask_d_next = jmask;
        jmask_next   = jmask << 1;
        if (jmask[DIM-1]) begin
          state_next = ST_SCAN_LAST;
        end
      end
      ST_SCAN_LAST: begin
        c_ra = q;
        c_we = 1'b1;
        c_wa = q;
        c_wd = ok_final;
        if (ok_final && !c_rd) begin
          cut_total_next = cut_total + CW'(1);
        end else if (!ok_final && c_rd) begin
          cut_total_next = cut_total - CW'(1);
        end
        if (kmask[DIM-1]) begin
          state_next = ST_DONE;
        end else begin
          kmask_next   = kmask << 1;
          jmask_next   = DIM'(1);
          jmask_d_next = '0;
          ok_next      = 1'b1;
          state_next   = ST_SCAN;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          point_value_next  = pv;
          point_is_cut_next = pc;
          true_count_next   = COUNT_W'(true_total);
          cut_count_next    = COUNT_W'(cut_total);
          out_valid_next    = 1'b1;
          state_next        = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/mfm_checker.sv
`timescale 1ns / 1ps
module mfm_checker import mfm_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               point_value,
  input logic               point_is_cut,
  input logic [COUNT_W-1:0] true_count,
  input logic [COUNT_W-1:0] cut_count
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(point_value) && $stable(point_is_cut)
      && $stable(true_count) && $stable(cut_count))
    else $error("stalled result word changed");

  // reset starts the clearing pass with nothing on the output
  a_reset_busy: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("block not busy or output valid after reset");

  // one word at a time: busy right after accepting
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while first still in work");

  // a new result only appears while the sequencer is busy finishing
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word appeared without work in progress");

endmodule

bind monotone_function_flip_mincut mfm_checker u_mfm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .point_value  (point_value),
  .point_is_cut (point_is_cut),
  .true_count   (true_count),
  .cut_count    (cut_count)
);
